// ----- sv/lom_pkg.sv -----
// Package: shared constants, codes and types of the limit order matcher.
package lom_pkg;
	localparam int DEF_SLOTS = 32;
	localparam int MAX_FILLS = 32;

	localparam logic [3:0] ST_DONE      = 4'd0;
	localparam logic [3:0] ST_RESTED    = 4'd1;
	localparam logic [3:0] ST_CANCELLED = 4'd2;
	localparam logic [3:0] ST_NOTFOUND  = 4'd3;
	localparam logic [3:0] ST_ZERO_ID   = 4'd4;
	localparam logic [3:0] ST_BAD_PRICE = 4'd5;
	localparam logic [3:0] ST_ZERO_QTY  = 4'd6;
	localparam logic [3:0] ST_DUP       = 4'd7;
	localparam logic [3:0] ST_FULL      = 4'd8;

	localparam logic REQ_NEW    = 1'b0;
	localparam logic REQ_CANCEL = 1'b1;

	localparam logic KIND_TRADE  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic [0:0]  req_type;
		logic [31:0] ord_num;
		logic [0:0]  side;
		logic [23:0] price;
		logic [31:0] quantity;
	} req_t;

	typedef struct packed {
		logic [0:0]  kind;
		logic [3:0]  status;
		logic [31:0] buyer_id;
		logic [31:0] seller_id;
		logic [23:0] trade_price;
		logic [31:0] fill_qty;
		logic [31:0] left_qty;
		logic [0:0]  last;
	} rsp_t;

	// Candidate travelling along the search chain.
	typedef struct packed {
		logic        hit;
		logic [23:0] price;
		logic [31:0] age;
		logic [31:0] ident;
		logic [31:0] amount;
	} cand_t;

	// Command broadcast from the controller to every cell.
	typedef enum logic [2:0] {
		OP_NONE, OP_FIND, OP_BEST, OP_FILL, OP_KILL, OP_REST
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] ident;
		logic        sell;
		logic [23:0] price;
		logic [31:0] amount;
		logic [31:0] arrival;
		logic [31:0] counter;
	} cmd_t;
endpackage

// ----- sv/lom_if.sv -----
// Interface: valid/ready channel carrying one payload of type T.
interface lom_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/lom_cell.sv -----
// Cell: one order slot plus its stage of the best-order and id search chain.
module lom_cell import lom_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        sel,       // this cell is the target of fill/kill/rest
	input  cand_t       cin,
	input  logic        free_in,   // a lower slot is free
	output cand_t       cout,
	output logic        free_out,
	output logic        is_free,
	output logic        match      // used slot whose id equals the command id
);
	logic        used_q;
	logic [31:0] ident_q;
	logic        sell_q;
	logic [23:0] limit_q;
	logic [31:0] amount_q;
	logic [31:0] arrival_q;
	logic [31:0] age;
	logic        elig, better;

	assign is_free  = ~used_q;
	assign free_out = free_in | ~used_q;
	assign match    = used_q && (ident_q == cmd.ident);
	assign age      = cmd.counter - arrival_q;
	assign elig     = used_q && (sell_q == cmd.sell);

	always_comb begin
		better = 1'b0;
		if (elig) begin
			if (!cin.hit) better = 1'b1;
			else if (cmd.sell ? (limit_q < cin.price) : (limit_q > cin.price)) better = 1'b1;
			else if (limit_q == cin.price && age > cin.age) better = 1'b1;
		end
	end

	// Registered hand-off to the neighbor; the chain settles over the slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout.hit <= 1'b0;
		end else if (better) begin
			cout <= '{1'b1, limit_q, age, ident_q, amount_q};
		end else begin
			cout <= cin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (sel) begin
			unique case (cmd.op)
				OP_FILL: begin
					amount_q <= amount_q - cmd.amount;
					if (amount_q == cmd.amount) used_q <= 1'b0;
				end
				OP_KILL: used_q <= 1'b0;
				OP_REST: begin
					used_q    <= 1'b1;
					ident_q   <= cmd.ident;
					sell_q    <= cmd.sell;
					limit_q   <= cmd.price;
					amount_q  <= cmd.amount;
					arrival_q <= cmd.arrival;
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- sv/limit_order_matcher.sv -----
// Top level: limit order book over a row of order-slot cells and one controller.
// A cancel or reject is checked in S_CHECK and its status registered there; a matched order
// passes S_SEARCH, where the best order ripples one registered cell per cycle, and S_DECIDE
// before each trade item is registered in S_EMIT; every item waits while the output is full.
// One transaction at a time: the next request is taken in the cycle after the status item
// is loaded. Reset empties the book and output at once.
module limit_order_matcher import lom_pkg::*; #(
	parameter int ORDER_SLOTS = DEF_SLOTS
) (
	input  logic clk,
	input  logic arst_n,
	lom_if.sink   req,
	lom_if.source rsp
);
	localparam int CW = $clog2(ORDER_SLOTS + 4);
	localparam int FW = $clog2(MAX_FILLS + 1);

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SEARCH, S_DECIDE, S_EMIT, S_REST}
		state_t;

	state_t      state_q;
	req_t        r_q;
	cmd_t        cmd;
	logic [31:0] counter_q;
	logic [CW-1:0] cnt_q;
	logic [FW-1:0] fills_q;
	cand_t       chain [ORDER_SLOTS+1];
	logic        freec [ORDER_SLOTS+1];
	cand_t       best;
	logic [ORDER_SLOTS-1:0] sel, is_free, match, low_free;
	logic        any_match, any_free;
	logic        out_free, chk_pass, crosses, cap_hit, rest_ok, out_load;
	logic [31:0] fill;
	rsp_t        out_d;
	rsp_t        out_q;
	logic        out_v_q;

	assign chain[0] = '0;
	assign freec[0] = 1'b0;
	assign any_match = |match;
	assign any_free  = freec[ORDER_SLOTS];
	assign best      = chain[ORDER_SLOTS];

	// The output register can take a new item when empty or drained this cycle.
	assign out_free = !out_v_q || rsp.ready;
	assign cap_hit  = (fills_q == FW'(MAX_FILLS));

	// A new order that passes every check goes on to matching.
	assign chk_pass = (r_q.req_type[0] == REQ_NEW) && (r_q.ord_num != '0) &&
		(r_q.price != '0) && (r_q.quantity != '0) && !any_match;

	// Prices cross: a sell at or below the best bid, a buy at or above the best ask.
	assign crosses = best.hit && !cap_hit &&
		(r_q.side[0] ? (r_q.price <= best.price) : (r_q.price >= best.price));

	// Rest only when the order survives with quantity, below the cap, and a slot is free.
	assign rest_ok = (r_q.quantity != '0) && !cap_hit && any_free;

	assign fill = (r_q.quantity < best.amount) ? r_q.quantity : best.amount;

	// Lowest free slot.
	assign low_free = is_free & ~(is_free - 1'b1);

	// Broadcast command: searches use the opposite side of the incoming order.
	// Write the book only at the edge where the matching result is registered.
	always_comb begin
		cmd         = '0;
		cmd.ident   = r_q.ord_num;
		cmd.sell    = ~r_q.side[0];
		cmd.price   = r_q.price;
		cmd.amount  = fill;
		cmd.arrival = counter_q;
		cmd.counter = counter_q;
		cmd.op      = OP_NONE;
		sel         = '0;
		if (state_q == S_EMIT && out_free) begin
			cmd.op    = OP_FILL;
			sel       = match;
			cmd.ident = best.ident;
		end else if (state_q == S_CHECK && r_q.req_type[0] == REQ_CANCEL && out_free) begin
			cmd.op = OP_KILL;
			sel    = match;
		end else if (state_q == S_REST && out_free && rest_ok) begin
			cmd.op     = OP_REST;
			cmd.sell   = r_q.side[0];
			cmd.amount = r_q.quantity;
			sel        = low_free;
		end
	end

	for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
		lom_cell u_cell (
			.clk, .arst_n, .cmd, .sel(sel[g]),
			.cin(chain[g]), .free_in(freec[g]), .cout(chain[g+1]),
			.free_out(freec[g+1]), .is_free(is_free[g]), .match(match[g])
		);
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_v_q;
	assign rsp.data  = out_q;

	// Next result item and when to load it.
	always_comb begin
		out_load       = 1'b0;
		out_d          = '0;
		out_d.kind     = KIND_STATUS;
		out_d.last     = 1'b1;
		out_d.left_qty = r_q.quantity;
		out_d.status   = ST_DONE;
		unique case (state_q)
			// Check order: cancel, zero id, zero price, zero quantity, duplicate id.
			S_CHECK: begin
				out_load = out_free && !chk_pass;
				if (r_q.req_type[0] == REQ_CANCEL) begin
					out_d.left_qty = '0;
					out_d.status   = any_match ? ST_CANCELLED : ST_NOTFOUND;
				end else if (r_q.ord_num == '0) begin
					out_d.status = ST_ZERO_ID;
				end else if (r_q.price == '0) begin
					out_d.status = ST_BAD_PRICE;
				end else if (r_q.quantity == '0) begin
					out_d.status = ST_ZERO_QTY;
				end else begin
					out_d.status = ST_DUP;
				end
			end
			// One trade at the resting price.
			S_EMIT: begin
				out_load          = out_free;
				out_d             = '0;
				out_d.kind        = KIND_TRADE;
				out_d.buyer_id    = r_q.side[0] ? best.ident : r_q.ord_num;
				out_d.seller_id   = r_q.side[0] ? r_q.ord_num : best.ident;
				out_d.trade_price = best.price;
				out_d.fill_qty    = fill;
			end
			// Final status: done, rested or book full.
			S_REST: begin
				out_load = out_free;
				if (rest_ok) out_d.status = ST_RESTED;
				else if (r_q.quantity == '0 || cap_hit) out_d.status = ST_DONE;
				else out_d.status = ST_FULL;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_v_q   <= 1'b0;
			counter_q <= '0;
			cnt_q     <= '0;
			fills_q   <= '0;
		end else begin
			if (out_load) begin
				out_q   <= out_d;
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (req.valid) begin
					r_q     <= req.data;
					fills_q <= '0;
					state_q <= S_CHECK;
				end
				S_CHECK: if (chk_pass) begin
					cnt_q   <= '0;
					state_q <= S_SEARCH;
				end else if (out_load) begin
					state_q <= S_IDLE;
				end
				// Let the candidate ripple through every cell.
				S_SEARCH: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(ORDER_SLOTS)) state_q <= S_DECIDE;
				end
				S_DECIDE: state_q <= crosses ? S_EMIT : S_REST;
				// Advance the remainder; the resting slot is updated by its id.
				S_EMIT: if (out_load) begin
					r_q.quantity <= r_q.quantity - fill;
					fills_q      <= fills_q + 1'b1;
					cnt_q        <= '0;
					state_q      <= (r_q.quantity == fill) ? S_REST : S_SEARCH;
				end
				S_REST: if (out_load) begin
					if (rest_ok) counter_q <= counter_q + 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
